>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising clock edge, skipped while reset is high.
`define RPQ_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on each rising clock edge, reset included.
`define RPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/rpq_pkg.sv
`default_nettype none

package rpq_pkg;

   // Built depth and fixed field widths
   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;
   localparam int PRIO_W        = 16;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 5;
   localparam int CAP_W         = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Operation codes
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPRIO = 2'd3;

   // One stored queue entry
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } entry_type;

   // Running best entry handed down the cell row
   typedef struct packed {
      logic      valid;
      entry_type ent;
   } carry_type;

   // Per-cycle commands broadcast to every cell
   typedef struct packed {
      logic wr_en;
      logic shift_en;
   } ctrl_type;

endpackage

`default_nettype wire

>>> hw/rtl/ring_priority_queue_unit.sv
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall req_kind, req_value, req_priority_req
// rsp      out        rsp_valid/rsp_stall rsp_status, rsp_out_value, rsp_out_priority,
//                                         rsp_count
// csr      in         csr_valid/csr_ready csr_active_capacity
//
// An insert, or a remove on an empty queue, sets the result register on accept, then the output register loads.
// A remove on a held queue first lets the carry ripple through all DEPTH cells; the gap
// closes and the result register loads on the last ripple edge, then the output register loads.
// Reset clears the count, the controller and the output valid flag; capacity goes to 16.
// Entry storage has no reset and no clearing pass; unheld cells are never read.
// A stalled result waits in the output register while the next item is accepted.
`default_nettype none

module ring_priority_queue_unit #(
   parameter int DEPTH = rpq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_kind,
   input  wire logic signed [rpq_pkg::VALUE_W-1:0] req_value,
   input  wire logic [rpq_pkg::PRIO_W-1:0]         req_priority_req,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [rpq_pkg::STATUS_W-1:0]            rsp_status,
   output logic signed [rpq_pkg::VALUE_W-1:0]      rsp_out_value,
   output logic [rpq_pkg::PRIO_W-1:0]              rsp_out_priority,
   output logic [rpq_pkg::COUNT_W-1:0]             rsp_count,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rpq_pkg::CAP_W-1:0]          csr_active_capacity
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH+1);
   localparam int CmpW = (CntW > rpq_pkg::CAP_W) ? CntW : rpq_pkg::CAP_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [CntW-1:0]                   scan_ff, scan_in;
   logic [CntW-1:0]                   count_ff, count_in;
   logic [rpq_pkg::CAP_W-1:0]         cap_ff, cap_in;
   logic [rpq_pkg::STATUS_W-1:0]      res_status_ff, res_status_in;
   logic signed [rpq_pkg::VALUE_W-1:0] res_value_ff, res_value_in;
   logic [rpq_pkg::PRIO_W-1:0]        res_prio_ff, res_prio_in;
   logic [CntW-1:0]                   res_count_ff, res_count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rpq_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic signed [rpq_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [rpq_pkg::PRIO_W-1:0]        rsp_prio_ff;
   logic [rpq_pkg::COUNT_W-1:0]       rsp_count_ff;

   logic                              accept;
   logic                              load_rsp;
   logic                              full;
   logic [rpq_pkg::CAP_W-1:0]         cap_lo;
   rpq_pkg::ctrl_type                 ctrl;
   logic [IdxW-1:0]                   best_idx;
   rpq_pkg::entry_type                wr_ent;

   rpq_pkg::carry_type                chain_c [DEPTH+1];
   logic [IdxW-1:0]                   chain_i [DEPTH+1];
   rpq_pkg::entry_type                chain_e [DEPTH+1];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign wr_ent.value = req_value;
   assign wr_ent.prio  = req_priority_req;

   // Capacity in effect saturates into 1 .. DEPTH
   assign cap_lo = (cap_ff == '0) ? rpq_pkg::CAP_W'(1) : cap_ff;
   assign full   = (CmpW'(count_ff) >= CmpW'(cap_lo)) || (count_ff == CntW'(DEPTH));

   // Row of cells: carry enters cell 0 empty, entries shift toward cell 0
   assign chain_c[0]     = '0;
   assign chain_i[0]     = '0;
   assign chain_e[DEPTH] = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      rpq_cell #(
         .DEPTH (DEPTH),
         .INDEX (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .count         (count_ff),
         .best_idx      (best_idx),
         .wr_ent        (wr_ent),
         .nbr_ent       (chain_e[g+1]),
         .carry_in      (chain_c[g]),
         .carry_idx_in  (chain_i[g]),
         .carry_out     (chain_c[g+1]),
         .carry_idx_out (chain_i[g+1]),
         .ent_out       (chain_e[g])
      );
   end

   // Sequence one item: decide, scan the row, close the gap, hand off
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_prio_in   = res_prio_ff;
      res_count_in  = res_count_ff;
      ctrl          = '0;
      best_idx      = chain_i[DEPTH];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_value_in = '0;
               res_prio_in  = '0;
               if (req_kind == rpq_pkg::KIND_INSERT) begin
                  if (req_priority_req == '0) begin
                     res_status_in = rpq_pkg::ST_BADPRIO;
                  end else if (full) begin
                     res_status_in = rpq_pkg::ST_FULL;
                  end else begin
                     res_status_in = rpq_pkg::ST_OK;
                     ctrl.wr_en    = 1'b1;
                     count_in      = count_ff + CntW'(1);
                  end
                  res_count_in = count_in;
                  state_in     = S_DONE;
               end else if (count_ff == '0) begin
                  res_status_in = rpq_pkg::ST_EMPTY;
                  res_count_in  = '0;
                  state_in      = S_DONE;
               end else begin
                  scan_in  = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_ff == CntW'(DEPTH - 1)) begin
               ctrl.shift_en = 1'b1;
               res_status_in = rpq_pkg::ST_OK;
               res_value_in  = chain_c[DEPTH].ent.value;
               res_prio_in   = chain_c[DEPTH].ent.prio;
               count_in      = count_ff - CntW'(1);
               res_count_in  = count_in;
               state_in      = S_DONE;
            end else begin
               scan_in = scan_ff + CntW'(1);
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   assign cap_in       = (csr_valid && csr_ready) ? csr_active_capacity : cap_ff;

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_prio_ff   <= res_prio_in;
      res_count_ff  <= res_count_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_prio_ff   <= res_prio_ff;
         rsp_count_ff  <= rpq_pkg::COUNT_W'(res_count_ff);
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= rpq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_count        = rsp_count_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rpq_cell.sv
`default_nettype none

module rpq_cell #(
   parameter int DEPTH = rpq_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rpq_pkg::ctrl_type           ctrl,
   input  wire logic [$clog2(DEPTH+1)-1:0]  count,
   input  wire logic [$clog2(DEPTH)-1:0]    best_idx,
   input  wire rpq_pkg::entry_type          wr_ent,
   input  wire rpq_pkg::entry_type          nbr_ent,
   input  wire rpq_pkg::carry_type          carry_in,
   input  wire logic [$clog2(DEPTH)-1:0]    carry_idx_in,
   output rpq_pkg::carry_type               carry_out,
   output logic [$clog2(DEPTH)-1:0]         carry_idx_out,
   output rpq_pkg::entry_type               ent_out
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH+1);
   localparam logic [CntW-1:0] MyPos  = CntW'(INDEX);
   localparam logic [CntW-1:0] NextPos = CntW'(INDEX + 1);
   localparam logic [IdxW-1:0] MyIdx  = IdxW'(INDEX);

   rpq_pkg::entry_type        ent_ff, ent_in;
   rpq_pkg::carry_type        carry_ff, carry_in_nxt;
   logic [IdxW-1:0]           cidx_ff, cidx_in;
   logic                      occupied;
   logic                      take_own;

   assign occupied = (count > MyPos);

   // Keep the carry unless this cell holds a strictly larger priority;
   // earlier cells win ties, so the oldest entry stays the best
   assign take_own = occupied &&
                     (!carry_in.valid || (ent_ff.prio > carry_in.ent.prio));

   always_comb begin
      if (take_own) begin
         carry_in_nxt.valid = 1'b1;
         carry_in_nxt.ent   = ent_ff;
         cidx_in            = MyIdx;
      end else begin
         carry_in_nxt       = carry_in;
         cidx_in            = carry_idx_in;
      end
   end

   // Write on insert at the tail, pull from the right neighbor to close a gap
   always_comb begin
      ent_in = ent_ff;
      if (ctrl.wr_en && (count == MyPos)) begin
         ent_in = wr_ent;
      end else if (ctrl.shift_en && (MyIdx >= best_idx) && (count > NextPos)) begin
         ent_in = nbr_ent;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      cidx_ff <= cidx_in;
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in_nxt;
      end
   end

   assign carry_out     = carry_ff;
   assign carry_idx_out = cidx_ff;
   assign ent_out       = ent_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rpq_checker.sv
`default_nettype none

`include "assert_macros.svh"

module rpq_checker #(
   parameter int DEPTH = rpq_pkg::DEPTH_DEFAULT
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [rpq_pkg::STATUS_W-1:0]       rsp_status,
   input wire logic signed [rpq_pkg::VALUE_W-1:0] rsp_out_value,
   input wire logic [rpq_pkg::PRIO_W-1:0]         rsp_out_priority,
   input wire logic [rpq_pkg::COUNT_W-1:0]        rsp_count
);

   // No result right after reset
   `RPQ_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // Held count never exceeds the built depth
   `RPQ_ASSERT_RST(a_count_bound, clock, reset, rsp_valid |-> (int'(rsp_count) <= DEPTH), "count beyond depth")

   // Failed results (any status but OK) carry zero payload
   `RPQ_ASSERT_RST(a_zero_payload, clock, reset, (rsp_valid && (rsp_status != rpq_pkg::ST_OK)) |-> ((rsp_out_value == 0) && (rsp_out_priority == 0)), "payload not cleared")

   // Empty remove reports an empty queue
   `RPQ_ASSERT_RST(a_empty_count, clock, reset, (rsp_valid && (rsp_status == rpq_pkg::ST_EMPTY)) |-> (rsp_count == 0), "empty status with entries")

   // Stalled result holds
   `RPQ_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_out_value) && $stable(rsp_count)), "stalled item changed")

endmodule

bind ring_priority_queue_unit rpq_checker #(
   .DEPTH (DEPTH)
) u_rpq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_out_value    (rsp_out_value),
   .rsp_out_priority (rsp_out_priority),
   .rsp_count        (rsp_count)
);

`default_nettype wire
